// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside of reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Checked on every clock edge, reset cycles included.
`define ASSERT_CLK_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) \
        else $error(msg);

`endif

// ===== rtl/tmag_pkg.sv =====
package tmag_pkg;

    localparam int CHANNEL_W  = 4;
    localparam int VALUE_W    = 12;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    // Register index, taken from paddr[2].
    localparam logic REG_CHANGE_LIMIT = 1'b0;

    localparam logic [VALUE_W-1:0] CHANGE_LIMIT_RESET = 12'd64;

    typedef struct packed {
        logic [CHANNEL_W-1:0] channel;
        logic [VALUE_W-1:0]   sample;
    } sample_req_t;

    typedef struct packed {
        logic [CHANNEL_W-1:0] out_channel;
        logic [VALUE_W-1:0]   round_mean;
        logic                 accepted;
        logic [VALUE_W-1:0]   held_value;
        logic                 channel_valid;
        logic                 ready_res;
    } result_t;

endpackage

// ===== rtl/trimmed_mean_adc_stability_gate.sv =====
// Trimmed-mean stability gate for a multi-channel converter stream.
//
// Input channel (s_valid/s_ready/s_data): one conversion request per item, tagged
// with its channel. Each channel collects SAMPLES_PER_ROUND samples; on the last one
// the mean without the largest and smallest sample is formed and compared with the
// channel's previous round mean. Requests for channels at or above CHANNELS are dropped.
// Result channel (m_valid/m_ready/m_data): one request per completed round, carrying
// the mean, whether it was within change_limit, the held value, the channel's valid
// mark and the global ready flag.
// Throughput is one sample per cycle, back to back, on any mix of channels, while
// the result channel is not stalled. A result for the request that completes a round
// runs through an input register, a trim stage, a reciprocal multiply stage and the
// output register. When the receiver stalls, each stage still takes a new item while
// the stage after it has room, so bubbles fill before s_ready drops. Reset (aresetn
// low, synchronous) empties the pipeline, restarts all rounds, clears previous and
// held means, valid marks and the ready flag, and sets change_limit to 64.
// change_limit sits at APB byte address 0; the user must write it only while the
// block is idle, as the block itself does not enforce this.
`include "assert_macros.svh"

module trimmed_mean_adc_stability_gate
    import tmag_pkg::*;
#(
    parameter int CHANNELS          = 16,
    parameter int SAMPLES_PER_ROUND = 6,
    parameter int SAMPLE_BITS       = 12
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  sample_req_t           s_data,

    output logic                  m_valid,
    input  logic                  m_ready,
    output result_t               m_data,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CNT_W    = $clog2(SAMPLES_PER_ROUND);
    localparam int SUM_W    = $clog2(SAMPLES_PER_ROUND * ((1 << SAMPLE_BITS) - 1) + 1);
    localparam int DIVISOR  = SAMPLES_PER_ROUND - 2;
    // Exact floor division by DIVISOR: multiply by ceil(2^SHIFT / DIVISOR), shift down.
    localparam int SHIFT    = SUM_W + $clog2(DIVISOR);
    localparam int RECIP_W  = SHIFT + 1;
    localparam int PROD_W   = SUM_W + RECIP_W;
    localparam int DIFF_W   = (SAMPLE_BITS > VALUE_W) ? SAMPLE_BITS : VALUE_W;

    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = '1;
    localparam logic [CNT_W-1:0]       CNT_LAST   = CNT_W'(SAMPLES_PER_ROUND - 1);

    // Configuration.
    logic [VALUE_W-1:0] limit_reg;

    // Per-channel state.
    logic [SUM_W-1:0]       sum_reg   [CHANNELS];
    logic [SAMPLE_BITS-1:0] max_reg   [CHANNELS];
    logic [SAMPLE_BITS-1:0] min_reg   [CHANNELS];
    logic [CNT_W-1:0]       cnt_reg   [CHANNELS];
    logic [SAMPLE_BITS-1:0] prev_reg  [CHANNELS];
    logic [SAMPLE_BITS-1:0] held_reg  [CHANNELS];
    logic                   mark_reg  [CHANNELS];
    logic                   ready_flag_reg;

    // Pipeline registers.
    logic                   in_valid_reg;
    sample_req_t            in_reg;
    logic                   trim_valid_reg;
    logic [CHANNEL_W-1:0]   trim_ch_reg;
    logic [SUM_W-1:0]       trim_reg;
    logic                   mean_valid_reg;
    logic [CHANNEL_W-1:0]   mean_ch_reg;
    logic [SAMPLE_BITS-1:0] mean_reg;
    logic                   m_valid_reg;
    result_t                m_data_reg;

    // Handshake chain: a stage moves on when the one after it has room.
    logic out_free;
    logic take_mean;
    logic mean_free;
    logic take_trim;
    logic trim_free;
    logic take_in;

    // Accumulate stage signals.
    logic [CH_IDX_W-1:0]    acc_idx;
    logic [SAMPLE_BITS-1:0] acc_smp;
    logic                   acc_in_range;
    logic [SUM_W-1:0]       sum_next;
    logic [SAMPLE_BITS-1:0] max_next;
    logic [SAMPLE_BITS-1:0] min_next;
    logic [CNT_W-1:0]       cnt_next;
    logic                   round_done;
    logic [SUM_W-1:0]       trim_next;

    // Divide stage signals.
    logic [PROD_W-1:0]      prod;
    logic [SAMPLE_BITS-1:0] mean_next;

    // Gate stage signals.
    logic [CH_IDX_W-1:0]    gate_idx;
    logic [SAMPLE_BITS-1:0] prev_mean;
    logic [SAMPLE_BITS-1:0] diff;
    logic                   ok;
    logic                   ready_flag_next;
    logic [SAMPLE_BITS-1:0] held_next;
    logic                   mark_next;

    assign out_free  = !m_valid_reg || m_ready;
    assign take_mean = mean_valid_reg && out_free;
    assign mean_free = !mean_valid_reg || out_free;
    assign take_trim = trim_valid_reg && mean_free;
    assign trim_free = !trim_valid_reg || mean_free;
    // Samples that do not close a round, or that are dropped, retire here at once.
    assign take_in   = in_valid_reg && (!(acc_in_range && round_done) || trim_free);
    assign s_ready   = !in_valid_reg || take_in;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Accumulate: update the channel's sum, extremes and count.
    always_comb begin
        acc_idx      = CH_IDX_W'(in_reg.channel);
        acc_smp      = SAMPLE_BITS'(in_reg.sample);
        acc_in_range = 32'(in_reg.channel) < 32'(CHANNELS);
        sum_next     = sum_reg[acc_idx] + SUM_W'(acc_smp);
        max_next     = (acc_smp > max_reg[acc_idx]) ? acc_smp : max_reg[acc_idx];
        min_next     = (acc_smp < min_reg[acc_idx]) ? acc_smp : min_reg[acc_idx];
        cnt_next     = cnt_reg[acc_idx] + CNT_W'(1);
        round_done   = cnt_reg[acc_idx] == CNT_LAST;
        trim_next    = sum_next - SUM_W'(max_next) - SUM_W'(min_next);
    end

    // Divide the trimmed sum by the number of kept samples.
    always_comb begin
        prod      = PROD_W'(trim_reg) * PROD_W'(RECIP);
        mean_next = prod[SHIFT +: SAMPLE_BITS];
    end

    // Gate: compare with the previous mean and update the held value, ready flag and valid mark.
    always_comb begin
        gate_idx        = CH_IDX_W'(mean_ch_reg);
        prev_mean       = prev_reg[gate_idx];
        diff            = (mean_reg >= prev_mean) ? (mean_reg - prev_mean)
                                                  : (prev_mean - mean_reg);
        ok              = DIFF_W'(diff) <= DIFF_W'(limit_reg);
        ready_flag_next = ready_flag_reg || (ok && (mean_reg != '0));
        held_next       = ok ? mean_reg : held_reg[gate_idx];
        mark_next       = mark_reg[gate_idx] || (ok && ready_flag_next);
    end

    // Control state and per-channel state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg      <= CHANGE_LIMIT_RESET;
            in_valid_reg   <= 1'b0;
            trim_valid_reg <= 1'b0;
            mean_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            ready_flag_reg <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
                sum_reg[i]  <= '0;
                max_reg[i]  <= '0;
                min_reg[i]  <= SAMPLE_MAX;
                cnt_reg[i]  <= '0;
                prev_reg[i] <= '0;
                held_reg[i] <= '0;
                mark_reg[i] <= 1'b0;
            end
        end else begin
            if (psel && penable && pwrite && (paddr[2] == REG_CHANGE_LIMIT)) begin
                limit_reg <= pwdata[VALUE_W-1:0];
            end

            if (s_ready) begin
                in_valid_reg <= s_valid;
            end

            if (take_in && acc_in_range) begin
                if (round_done) begin
                    sum_reg[acc_idx] <= '0;
                    max_reg[acc_idx] <= '0;
                    min_reg[acc_idx] <= SAMPLE_MAX;
                    cnt_reg[acc_idx] <= '0;
                end else begin
                    sum_reg[acc_idx] <= sum_next;
                    max_reg[acc_idx] <= max_next;
                    min_reg[acc_idx] <= min_next;
                    cnt_reg[acc_idx] <= cnt_next;
                end
            end

            if (trim_free) begin
                trim_valid_reg <= take_in && acc_in_range && round_done;
            end

            if (mean_free) begin
                mean_valid_reg <= take_trim;
            end

            if (out_free) begin
                m_valid_reg <= take_mean;
            end

            if (take_mean) begin
                prev_reg[gate_idx] <= mean_reg;
                held_reg[gate_idx] <= held_next;
                mark_reg[gate_idx] <= mark_next;
                ready_flag_reg     <= ready_flag_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_reg <= s_data;
        end
        if (trim_free) begin
            trim_ch_reg <= in_reg.channel;
            trim_reg    <= trim_next;
        end
        if (mean_free) begin
            mean_ch_reg <= trim_ch_reg;
            mean_reg    <= mean_next;
        end
        if (out_free) begin
            m_data_reg.out_channel   <= mean_ch_reg;
            m_data_reg.round_mean    <= VALUE_W'(mean_reg);
            m_data_reg.accepted      <= ok;
            m_data_reg.held_value    <= VALUE_W'(held_next);
            m_data_reg.channel_valid <= mark_next;
            m_data_reg.ready_res     <= ready_flag_next;
        end
    end

    // Configuration read-back.
    assign pready = 1'b1;
    always_comb begin
        if (paddr[2] == REG_CHANGE_LIMIT) begin
            prdata = CFG_DATA_W'(limit_reg);
        end else begin
            prdata = '0;
        end
    end

    // An accepted round must show its own mean as the held value.
    `ASSERT_CLK(a_held_follows_accept, m_valid_reg && m_data_reg.accepted |-> (m_data_reg.held_value == m_data_reg.round_mean), "held value differs from accepted mean")
    // A channel can only be marked valid once the global flag is up.
    `ASSERT_CLK(a_mark_needs_ready, m_valid_reg && m_data_reg.channel_valid |-> m_data_reg.ready_res, "channel valid without ready")
    // An accepted nonzero mean always raises the ready flag.
    `ASSERT_CLK(a_ready_on_nonzero, m_valid_reg && m_data_reg.accepted && (m_data_reg.round_mean != '0) |-> m_data_reg.ready_res, "ready flag missed a nonzero mean")
    // Dropped channels never reach the trim stage.
    `ASSERT_CLK(a_trim_in_range, trim_valid_reg |-> (32'(trim_ch_reg) < 32'(CHANNELS)), "out-of-range channel in pipeline")
    // Reset empties the output register.
    `ASSERT_CLK_RST(a_reset_clears_out, !aresetn |=> !m_valid_reg, "result valid after reset")

endmodule
